@@ rtl/efd_pkg.sv @@
// Shared types, constants and calendar tables for the Easter feast date unit.
// Used by the channel interfaces, the sequencer and the constant divider.
// Depends on nothing.
package efd_pkg;

    localparam int YEAR_WIDTH = 16;
    localparam int YEAR_IN_W  = 16;
    localparam int FEAST_W    = 3;
    localparam int MONTH_W    = 4;
    localparam int DOM_W      = 5;
    localparam int DOY_W      = 9;

    // Divider operand width, remainder width and width of the century count.
    localparam int XW = YEAR_WIDTH;
    localparam int RW = 9;
    localparam int BW = XW - 6;

    localparam logic [FEAST_W-1:0] FEAST_LAST  = 3'd6;
    localparam logic [MONTH_W-1:0] MONTH_COUNT = 4'd12;

    typedef enum logic [2:0] {
        DIV_19,
        DIV_100,
        DIV_25,
        DIV_3,
        DIV_30,
        DIV_7,
        DIV_451,
        DIV_31
    } div_kind_t;

    typedef struct packed {
        logic            start;
        div_kind_t       kind;
        logic [XW-1:0]   x;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [XW-1:0]   q;
        logic [RW-1:0]   r;
    } div_rsp_t;

    // Floor reciprocals scaled by 2^XW; the estimate is at most one below the quotient.
    localparam logic [XW-1:0] RECIP_19  = XW'((64'd1 << XW) / 64'd19);
    localparam logic [XW-1:0] RECIP_100 = XW'((64'd1 << XW) / 64'd100);
    localparam logic [XW-1:0] RECIP_25  = XW'((64'd1 << XW) / 64'd25);
    localparam logic [XW-1:0] RECIP_3   = XW'((64'd1 << XW) / 64'd3);
    localparam logic [XW-1:0] RECIP_30  = XW'((64'd1 << XW) / 64'd30);
    localparam logic [XW-1:0] RECIP_7   = XW'((64'd1 << XW) / 64'd7);
    localparam logic [XW-1:0] RECIP_451 = XW'((64'd1 << XW) / 64'd451);
    localparam logic [XW-1:0] RECIP_31  = XW'((64'd1 << XW) / 64'd31);

    function automatic logic [RW-1:0] div_const(input div_kind_t kind);
        logic [RW-1:0] k;
        unique case (kind)
            DIV_19:  k = 9'd19;
            DIV_100: k = 9'd100;
            DIV_25:  k = 9'd25;
            DIV_3:   k = 9'd3;
            DIV_30:  k = 9'd30;
            DIV_7:   k = 9'd7;
            DIV_451: k = 9'd451;
            DIV_31:  k = 9'd31;
            default: k = 9'd31;
        endcase
        return k;
    endfunction

    function automatic logic [XW-1:0] div_recip(input div_kind_t kind);
        logic [XW-1:0] rc;
        unique case (kind)
            DIV_19:  rc = RECIP_19;
            DIV_100: rc = RECIP_100;
            DIV_25:  rc = RECIP_25;
            DIV_3:   rc = RECIP_3;
            DIV_30:  rc = RECIP_30;
            DIV_7:   rc = RECIP_7;
            DIV_451: rc = RECIP_451;
            DIV_31:  rc = RECIP_31;
            default: rc = RECIP_31;
        endcase
        return rc;
    endfunction

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] cum;
        unique case (m)
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        if (m > 4'd2 && leap)
        begin
            cum = cum + 9'd1;
        end
        return cum;
    endfunction

    // Offset of each feast from Easter Sunday, as a nine-bit two's complement value.
    function automatic logic [DOY_W-1:0] feast_offset(input logic [FEAST_W-1:0] n);
        logic [DOY_W-1:0] off;
        unique case (n)
            3'd0:    off = 9'(-49);
            3'd1:    off = 9'(-47);
            3'd2:    off = 9'(-2);
            3'd3:    off = 9'd0;
            3'd4:    off = 9'd39;
            3'd5:    off = 9'd50;
            3'd6:    off = 9'd56;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

@@ rtl/efd_if.sv @@
// Request channels of the Easter feast date unit: years in, feast dates out.
// Depends on efd_pkg for the field widths.
interface efd_year_if;
    import efd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [YEAR_IN_W-1:0] year;

    modport source (output valid, output year, input ready);
    modport sink   (input valid, input year, output ready);
endinterface

interface efd_feast_if;
    import efd_pkg::*;

    logic               valid;
    logic               ready;
    logic [FEAST_W-1:0] feast;
    logic [MONTH_W-1:0] month_of_date;
    logic [DOM_W-1:0]   day_of_month;
    logic [DOY_W-1:0]   day_of_year;
    logic               last;

    modport source (output valid, output feast, output month_of_date, output day_of_month,
                    output day_of_year, output last, input ready);
    modport sink   (input valid, input feast, input month_of_date, input day_of_month,
                    input day_of_year, input last, output ready);
endinterface

@@ rtl/efd_cdiv.sv @@
// Shared divide-by-constant unit: the reciprocal product is registered, then the corrected quotient and remainder.
// Depends on efd_pkg for the request/response structs and reciprocal tables.
module efd_cdiv (
    input  logic              clk,
    input  logic              rst_n,
    input  efd_pkg::div_req_t req,
    output efd_pkg::div_rsp_t rsp
);
    import efd_pkg::*;

    logic              s1_reg;
    logic              done_reg;
    logic [2*XW-1:0]   prod_reg;
    logic [XW-1:0]     x_reg;
    div_kind_t         kind_reg;
    logic [XW-1:0]     q_reg;
    logic [RW-1:0]     r_reg;

    logic [XW-1:0]     q_est;
    logic [RW-1:0]     k_val;
    logic [XW+RW-1:0]  qk_full;
    logic [XW-1:0]     rem_full;
    logic [RW:0]       rem_est;
    logic [XW-1:0]     q_next;
    logic [RW-1:0]     r_next;

    always_comb
    begin
        q_est    = prod_reg[2*XW-1:XW];
        k_val    = div_const(kind_reg);
        qk_full  = (XW+RW)'(q_est) * (XW+RW)'(k_val);
        rem_full = x_reg - qk_full[XW-1:0];
        rem_est  = rem_full[RW:0];
        // The estimate can fall one short; a single compare and subtract fixes it.
        if (rem_est >= {1'b0, k_val})
        begin
            q_next = q_est + XW'(1);
            r_next = RW'(rem_est - {1'b0, k_val});
        end
        else
        begin
            q_next = q_est;
            r_next = rem_est[RW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= req.start;
            done_reg <= s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= (2*XW)'(req.x) * (2*XW)'(div_recip(req.kind));
            x_reg    <= req.x;
            kind_reg <= req.kind;
        end
        if (s1_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;
    assign rsp.r    = r_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> ##1 rsp.done)
        else $error("divider result did not arrive two cycles after start");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (rsp.r < div_const(kind_reg)))
        else $error("divider remainder not below divisor");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> !req.start)
        else $error("divider started again while busy");

endmodule

@@ rtl/efd_ctrl.sv @@
// Sequencer: runs the computus through the shared divider, then walks months
// for each of the seven feasts and holds the result register.
// Depends on efd_pkg and the channel interfaces in efd_if.
module efd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    efd_year_if.sink          years,
    efd_feast_if.source       dates,
    output efd_pkg::div_req_t div_req,
    input  efd_pkg::div_rsp_t div_rsp
);
    import efd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A,
        S_B,
        S_F,
        S_G,
        S_H,
        S_L,
        S_M,
        S_BASE,
        S_ORD,
        S_WALK,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic               busy_reg;
    logic [XW-1:0]      y_reg;
    logic [4:0]         a_reg;
    logic [BW-1:0]      b_reg;
    logic [6:0]         c_reg;
    logic [BW-1:0]      f_reg;
    logic [BW-1:0]      g_reg;
    logic [4:0]         h_reg;
    logic [2:0]         l_reg;
    logic               m_reg;
    logic [MONTH_W-1:0] emon_reg;
    logic [DOM_W-1:0]   eday_reg;
    logic               leap_reg;
    logic [DOY_W-1:0]   easter_reg;
    logic [FEAST_W-1:0] feast_reg;
    logic [DOY_W-1:0]   ord_reg;
    logic [DOY_W-1:0]   rest_reg;
    logic [MONTH_W-1:0] mon_reg;

    logic               out_valid_reg;
    logic [FEAST_W-1:0] out_feast_reg;
    logic [MONTH_W-1:0] out_month_reg;
    logic [DOM_W-1:0]   out_dom_reg;
    logic [DOY_W-1:0]   out_doy_reg;
    logic               out_last_reg;

    logic [BW-3:0]      d_w;
    logic [1:0]         e_w;
    logic [4:0]         i_w;
    logic [1:0]         k_w;
    logic               leap_w;
    logic [DOY_W-1:0]   easter_w;
    logic [4:0]         len_w;
    logic               is_div;
    logic               out_free;

    assign d_w = b_reg[BW-1:2];
    assign e_w = b_reg[1:0];
    assign i_w = c_reg[6:2];
    assign k_w = c_reg[1:0];

    // Divisible by 400 means a whole century count that is a multiple of four.
    assign leap_w   = (c_reg == 7'd0) ? (e_w == 2'd0) : (y_reg[1:0] == 2'b00);
    assign easter_w = days_before(emon_reg, leap_w) + DOY_W'(eday_reg);
    assign len_w    = month_len(mon_reg, leap_reg);
    assign out_free = !out_valid_reg || dates.ready;

    always_comb
    begin
        is_div       = 1'b1;
        div_req.kind = DIV_19;
        div_req.x    = y_reg;
        unique case (state_reg)
            S_A:
            begin
                div_req.kind = DIV_19;
                div_req.x    = y_reg;
            end
            S_B:
            begin
                div_req.kind = DIV_100;
                div_req.x    = y_reg;
            end
            S_F:
            begin
                div_req.kind = DIV_25;
                div_req.x    = XW'(b_reg) + XW'(8);
            end
            S_G:
            begin
                div_req.kind = DIV_3;
                div_req.x    = XW'(b_reg) - XW'(f_reg) + XW'(1);
            end
            S_H:
            begin
                div_req.kind = DIV_30;
                div_req.x    = XW'(10'(a_reg) * 10'd19) + XW'(b_reg) - XW'(d_w)
                               - XW'(g_reg) + XW'(15);
            end
            S_L:
            begin
                div_req.kind = DIV_7;
                div_req.x    = XW'(8'd32 + 8'({e_w, 1'b0}) + 8'({i_w, 1'b0})
                                   - 8'(h_reg) - 8'(k_w));
            end
            S_M:
            begin
                div_req.kind = DIV_451;
                div_req.x    = XW'(10'(a_reg) + 10'(h_reg) * 10'd11 + 10'(l_reg) * 10'd22);
            end
            S_BASE:
            begin
                div_req.kind = DIV_31;
                div_req.x    = XW'(8'(h_reg) + 8'(l_reg) + 8'd114 - (m_reg ? 8'd7 : 8'd0));
            end
            default:
            begin
                is_div = 1'b0;
            end
        endcase
        div_req.start = is_div && !busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            y_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            f_reg         <= '0;
            g_reg         <= '0;
            h_reg         <= '0;
            l_reg         <= '0;
            m_reg         <= 1'b0;
            emon_reg      <= '0;
            eday_reg      <= '0;
            leap_reg      <= 1'b0;
            easter_reg    <= '0;
            feast_reg     <= '0;
            ord_reg       <= '0;
            rest_reg      <= '0;
            mon_reg       <= '0;
            out_feast_reg <= '0;
            out_month_reg <= '0;
            out_dom_reg   <= '0;
            out_doy_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // In the emit state the load below decides the next valid.
            if (out_valid_reg && dates.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            if (is_div)
            begin
                if (!busy_reg)
                begin
                    busy_reg <= 1'b1;
                end
                else if (div_rsp.done)
                begin
                    busy_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (years.valid)
                    begin
                        y_reg     <= XW'(years.year);
                        state_reg <= S_A;
                    end
                end
                S_A:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        a_reg     <= div_rsp.r[4:0];
                        state_reg <= S_B;
                    end
                end
                S_B:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        b_reg     <= div_rsp.q[BW-1:0];
                        c_reg     <= div_rsp.r[6:0];
                        state_reg <= S_F;
                    end
                end
                S_F:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        f_reg     <= div_rsp.q[BW-1:0];
                        state_reg <= S_G;
                    end
                end
                S_G:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        g_reg     <= div_rsp.q[BW-1:0];
                        state_reg <= S_H;
                    end
                end
                S_H:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        h_reg     <= div_rsp.r[4:0];
                        state_reg <= S_L;
                    end
                end
                S_L:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        l_reg     <= div_rsp.r[2:0];
                        state_reg <= S_M;
                    end
                end
                S_M:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        m_reg     <= div_rsp.q[0];
                        state_reg <= S_BASE;
                    end
                end
                S_BASE:
                begin
                    if (busy_reg && div_rsp.done)
                    begin
                        emon_reg  <= div_rsp.q[MONTH_W-1:0];
                        eday_reg  <= div_rsp.r[DOM_W-1:0] + DOM_W'(1);
                        state_reg <= S_ORD;
                    end
                end
                S_ORD:
                begin
                    leap_reg   <= leap_w;
                    easter_reg <= easter_w;
                    feast_reg  <= '0;
                    ord_reg    <= easter_w + feast_offset('0);
                    rest_reg   <= easter_w + feast_offset('0);
                    mon_reg    <= MONTH_W'(1);
                    state_reg  <= S_WALK;
                end
                S_WALK:
                begin
                    // One month per cycle until the remainder fits the current month or the month reaches December.
                    if (mon_reg < MONTH_COUNT && rest_reg > DOY_W'(len_w))
                    begin
                        rest_reg <= rest_reg - DOY_W'(len_w);
                        mon_reg  <= mon_reg + MONTH_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_feast_reg <= feast_reg;
                        out_month_reg <= mon_reg;
                        out_dom_reg   <= rest_reg[DOM_W-1:0];
                        out_doy_reg   <= ord_reg;
                        out_last_reg  <= (feast_reg == FEAST_LAST);
                        if (feast_reg == FEAST_LAST)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            feast_reg <= feast_reg + FEAST_W'(1);
                            ord_reg   <= easter_reg + feast_offset(feast_reg + FEAST_W'(1));
                            rest_reg  <= easter_reg + feast_offset(feast_reg + FEAST_W'(1));
                            mon_reg   <= MONTH_W'(1);
                            state_reg <= S_WALK;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign years.ready         = (state_reg == S_IDLE);
    assign dates.valid         = out_valid_reg;
    assign dates.feast         = out_feast_reg;
    assign dates.month_of_date = out_month_reg;
    assign dates.day_of_month  = out_dom_reg;
    assign dates.day_of_year   = out_doy_reg;
    assign dates.last          = out_last_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (years.valid && years.ready) |=> !years.ready)
        else $error("year request taken while the previous one is in progress");

    a_date_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dates.valid |-> (dates.day_of_month != 5'd0 && dates.month_of_date != 4'd0
                         && dates.month_of_date <= MONTH_COUNT))
        else $error("feast date outside the calendar");

    a_rsp_only_when_issued: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (busy_reg && is_div))
        else $error("divider response without an outstanding request");

endmodule

@@ rtl/easter_feast_dates_unit.sv @@
// Top level of the Easter feast date unit: sequencer plus shared constant divider.
// Depends on efd_pkg, efd_if, efd_cdiv and efd_ctrl.
//
//  channel  dir  payload                                                    handshake
//  years    in   year[15:0]                                                 valid/ready
//  dates    out  feast, month_of_date, day_of_month, day_of_year, last      valid/ready
//
// For each year the idle state takes the year, eight constant divisions run on the shared
// divider, a state places Easter in the year, then for each of the seven feasts a month
// walk runs one month per cycle until the date fits, then a state loads the result
// register.
// The unit takes a new year only after the seventh result has been loaded.
// A stalled output holds the sequencer before the next load; reset clears the sequencer
// and output valid.
module easter_feast_dates_unit (
    input  logic        clk,
    input  logic        rst_n,
    efd_year_if.sink    years,
    efd_feast_if.source dates
);
    import efd_pkg::*;

    div_req_t div_req;
    div_rsp_t div_rsp;

    efd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .years   (years),
        .dates   (dates),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    efd_cdiv u_cdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for easter_feast_dates_unit: drives years, predicts the seven feast
// dates of each year and checks every date request in order.
// Depends on efd_pkg, efd_if and the RTL of the unit.
`timescale 1ns / 1ps

module testbench;
    import efd_pkg::*;

    localparam int FEAST_COUNT  = 7;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RESET_CYCLES = 9;

    typedef enum logic [FEAST_W-1:0] {
        FEAST_CARNIVAL_START,
        FEAST_CARNIVAL_END,
        FEAST_GOOD_FRIDAY,
        FEAST_EASTER,
        FEAST_ASCENSION,
        FEAST_WHITSUN_START,
        FEAST_WHITSUN_END
    } feast_e;

    typedef struct {
        logic [YEAR_IN_W-1:0] year;
        logic [FEAST_W-1:0]   feast;
        logic [MONTH_W-1:0]   month;
        logic [DOM_W-1:0]     dom;
        logic [DOY_W-1:0]     doy;
        logic                 last;
    } feast_date_t;

    logic clk;
    logic rst_n;

    efd_year_if  years_ch ();
    efd_feast_if dates_ch ();

    easter_feast_dates_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .years (years_ch),
        .dates (dates_ch)
    );

    feast_date_t feast_q[$];
    int          error_count;
    bit          src_idle;
    bit          sink_idle;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int month_days(input int y, input int m);
        if (m == 4 || m == 6 || m == 9 || m == 11)
        begin
            return 30;
        end
        if (m == 2)
        begin
            return is_leap(y) ? 29 : 28;
        end
        return 31;
    endfunction

    function automatic int feast_shift(input feast_e f);
        case (f)
            FEAST_CARNIVAL_START: return -49;
            FEAST_CARNIVAL_END:   return -47;
            FEAST_GOOD_FRIDAY:    return -2;
            FEAST_EASTER:         return 0;
            FEAST_ASCENSION:      return 39;
            FEAST_WHITSUN_START:  return 50;
            default:              return 56;
        endcase
    endfunction

    // Anonymous Gregorian computus, giving Easter Sunday as a day of the year.
    function automatic int easter_ordinal_of(input int y);
        int a, b, c, d, e, f, g, h, i, k, l, m, base, mon, ord;
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - d - g + 15) % 30;
        i = c / 4;
        k = c % 4;
        l = (32 + 2 * e + 2 * i - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        base = h + l - 7 * m + 114;
        mon = base / 31;
        ord = base % 31 + 1;
        for (int j = 1; j < mon && j <= 12; j++)
        begin
            ord += month_days(y, j);
        end
        return ord;
    endfunction

    task automatic queue_feast_dates(input logic [YEAR_IN_W-1:0] y);
        feast_date_t fd;
        int          yr, easter, ord, rest, mon;
        yr = int'(y);
        easter = easter_ordinal_of(yr);
        for (int n = 0; n < FEAST_COUNT; n++)
        begin
            ord = easter + feast_shift(feast_e'(n));
            rest = ord;
            mon = 1;
            while (mon < 12 && rest > month_days(yr, mon))
            begin
                rest -= month_days(yr, mon);
                mon++;
            end
            fd.year  = y;
            fd.feast = FEAST_W'(n);
            fd.month = MONTH_W'(mon);
            fd.dom   = DOM_W'(rest);
            fd.doy   = DOY_W'(ord);
            fd.last  = (feast_e'(n) == FEAST_WHITSUN_END);
            feast_q.push_back(fd);
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : date_checker
        feast_date_t fd;
        if (rst_n && dates_ch.valid && dates_ch.ready)
        begin
            if (feast_q.size() == 0)
            begin
                report_mismatch($sformatf("date request with no year pending (feast %0d)",
                                          dates_ch.feast));
            end
            else
            begin
                fd = feast_q.pop_front();
                if (dates_ch.feast !== fd.feast)
                    report_mismatch($sformatf("year %0d feast got %0d exp %0d",
                                              fd.year, dates_ch.feast, fd.feast));
                if (dates_ch.month_of_date !== fd.month)
                    report_mismatch($sformatf("year %0d feast %0d month got %0d exp %0d",
                                              fd.year, fd.feast, dates_ch.month_of_date,
                                              fd.month));
                if (dates_ch.day_of_month !== fd.dom)
                    report_mismatch($sformatf("year %0d feast %0d day got %0d exp %0d",
                                              fd.year, fd.feast, dates_ch.day_of_month,
                                              fd.dom));
                if (dates_ch.day_of_year !== fd.doy)
                    report_mismatch($sformatf("year %0d feast %0d ordinal got %0d exp %0d",
                                              fd.year, fd.feast, dates_ch.day_of_year,
                                              fd.doy));
                if (dates_ch.last !== fd.last)
                    report_mismatch($sformatf("year %0d feast %0d last got %0b exp %0b",
                                              fd.year, fd.feast, dates_ch.last, fd.last));
            end
        end
    end

    // ---------------------------------------------------------------- output stalls

    initial
    begin : date_sink
        int stall_left;
        stall_left = 0;
        dates_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0)
            begin
                dates_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                dates_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((years_ch.valid && years_ch.ready) || (dates_ch.valid && dates_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[%0t] no request moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAIL easter_feast_dates_unit");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    // Valid stays high from one year to the next unless an idle burst falls between them.
    task automatic send_year(input logic [YEAR_IN_W-1:0] y);
        int gap;
        gap = 0;
        if (src_idle && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 15);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            years_ch.valid <= 1'b0;
            years_ch.year  <= YEAR_IN_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        years_ch.valid <= 1'b1;
        years_ch.year  <= y;
        do
            @(posedge clk);
        while (!years_ch.ready);
        queue_feast_dates(y);
    endtask

    task automatic test_directed_years();
        logic [YEAR_IN_W-1:0] years_list[$];
        years_list = '{16'd1, 16'hFFFF, 16'd0, 16'd2000, 16'd1900, 16'd2024, 16'd2019,
                       16'd1818, 16'd2285, 16'd1943, 16'd2038, 16'd1954, 16'd1981,
                       16'd1583, 16'd100, 16'd400, 16'd4096, 16'h8000, 16'h5555,
                       16'hAAAA, 16'd8000, 16'd2100, 16'd1600};
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        foreach (years_list[n])
        begin
            send_year(years_list[n]);
        end
    endtask

    task automatic test_random_years(input int count);
        logic [YEAR_IN_W-1:0] y;
        int                   pick;
        for (int n = 0; n < count; n++)
        begin
            // Long stretches with idling switched on or off at random on each side.
            if (n % 40 == 0)
            begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)
                y = YEAR_IN_W'($urandom_range(1583, 2600));
            else if (pick < 9)
                y = YEAR_IN_W'($urandom);
            else
                y = YEAR_IN_W'($urandom_range(0, 8)) * 16'd100;
            send_year(y);
        end
    endtask

    task automatic test_back_to_back_years(input int count);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            send_year(YEAR_IN_W'($urandom));
        end
    endtask

    initial
    begin
        error_count = 0;
        src_idle = 1'b0;
        sink_idle = 1'b0;
        rst_n = 1'b0;
        years_ch.valid = 1'b0;
        years_ch.year  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_years();
        test_random_years(250);
        test_back_to_back_years(30);

        @(negedge clk);
        years_ch.valid <= 1'b0;
        wait (feast_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS easter_feast_dates_unit");
        end
        else
        begin
            $display("FAIL easter_feast_dates_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/efd_pkg.sv
rtl/efd_if.sv
rtl/efd_cdiv.sv
rtl/efd_ctrl.sv
rtl/easter_feast_dates_unit.sv
bench/testbench.sv
